// ===== rtl/core/dtfd_pkg.sv =====
// Shared types, constants and tables of the double to decimal text formatter.
package dtfd_pkg;

  localparam int XW = 113;  // widest exact product: 53-bit fraction times 10^18
  localparam int NDIG = 20;  // BCD digits held for either part

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_NUL   = 7'h00;

  localparam logic [10:0] EXP_ALL = 11'h7FF;
  localparam logic [62:0] MAG_TWO_53 = 63'h4340000000000000;

  localparam logic [0:0] REG_FRACTION_DIGITS = 1'b0;
  localparam logic [0:0] REG_COMPACT_MODE    = 1'b1;

  // one decoded word waiting for the back end
  typedef struct packed {
    logic        err;
    logic        neg;
    logic [53:0] whole;
    logic [52:0] frac;
    logic [10:0] shift;
    logic [4:0]  digits;
    logic        compact;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_NORM, ST_ROUND, ST_CARRY, ST_CONV, ST_SCAN,
    ST_SIGN, ST_INT, ST_DOT, ST_FRAC, ST_ERR
  } state_t;

  function automatic logic [63:0] pow10(input logic [4:0] d);
    logic [63:0] p;
    begin
      case (d)
        5'd0:  p = 64'd1;
        5'd1:  p = 64'd10;
        5'd2:  p = 64'd100;
        5'd3:  p = 64'd1000;
        5'd4:  p = 64'd10000;
        5'd5:  p = 64'd100000;
        5'd6:  p = 64'd1000000;
        5'd7:  p = 64'd10000000;
        5'd8:  p = 64'd100000000;
        5'd9:  p = 64'd1000000000;
        5'd10: p = 64'd10000000000;
        5'd11: p = 64'd100000000000;
        5'd12: p = 64'd1000000000000;
        5'd13: p = 64'd10000000000000;
        5'd14: p = 64'd100000000000000;
        5'd15: p = 64'd1000000000000000;
        5'd16: p = 64'd10000000000000000;
        5'd17: p = 64'd100000000000000000;
        default: p = 64'd1000000000000000000;
      endcase
      return p;
    end
  endfunction

endpackage

// ===== rtl/core/dtfd_front.sv =====
// Front end: split a binary64 pattern into whole part, fraction and scale.
module dtfd_front import dtfd_pkg::*; #(
  parameter int MAX_FRACTION_DIGITS = 18
) (
  input  logic [63:0] value_bits,
  input  logic [4:0]  fraction_digits,
  input  logic        compact_mode,
  output job_t        job
);

  logic [10:0] expo;
  logic [62:0] mag;
  logic [52:0] mant;
  logic [10:0] e_eff;
  logic [11:0] s_full;
  logic [5:0]  s_lo;

  always_comb begin
    expo   = value_bits[62:52];
    mag    = value_bits[62:0];
    mant   = {(expo != 11'd0), value_bits[51:0]};
    e_eff  = (expo == 11'd0) ? 11'd1 : expo;
    s_full = 12'd1075 - {1'b0, e_eff};
    s_lo   = s_full[5:0];

    job         = '0;
    job.err     = (expo == EXP_ALL) || (mag > MAG_TWO_53);
    job.neg     = value_bits[63] && (mag != 63'd0);
    job.compact = compact_mode;
    job.digits  = (fraction_digits > 5'(MAX_FRACTION_DIGITS)) ?
                  5'(MAX_FRACTION_DIGITS) : fraction_digits;

    if (s_full[11]) begin
      // exactly 2^53: all integer
      job.whole = {mant, 1'b0};
      job.frac  = '0;
      job.shift = '0;
    end else if (s_full[10:0] >= 11'd53) begin
      job.whole = '0;
      job.frac  = mant;
      job.shift = s_full[10:0];
    end else begin
      job.whole = {1'b0, mant >> s_lo};
      job.frac  = mant & ~({53{1'b1}} << s_lo);
      job.shift = s_full[10:0];
    end
  end

endmodule

// ===== rtl/core/dtfd_queue.sv =====
// Small register queue between the front and back ends.
module dtfd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/core/dtfd_back.sv =====
// Back end: scale, round, convert to BCD and emit the characters.
module dtfd_back import dtfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       job,
  input  logic       job_valid,
  output logic       job_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [6:0] out_text_char,
  output logic       out_last_char,
  output logic       out_out_of_range
);

  state_t state_r, state_nxt;

  logic           neg_r, compact_r;
  logic [53:0]    whole_r;
  logic [10:0]    s_r;
  logic [4:0]     d_r;
  logic [XW-1:0]  x_r;
  logic [6:0]     q_r;
  logic           guard_r, sticky_r;
  logic [5:0]     cnt_r;
  logic [63:0]    t_r, ip_sh_r, fp_sh_r;
  logic [NDIG*4-1:0] ibcd_r, fbcd_r;
  logic [NDIG*4-1:0] ibcd_adj, fbcd_adj;
  logic [4:0]     ptr_r, fstop_r;

  logic        out_valid_r, out_last_r, out_oor_r;
  logic [6:0]  out_char_r;

  logic        emit_valid, emit_last, emit_oor, emit_ok;
  logic [6:0]  emit_char;
  logic        x_big;

  // rounding of the scaled fraction
  logic [53:0] rnd_m;
  logic [11:0] sh, neg_sh;
  logic [65:0] sum66, shr66;
  logic [63:0] t_nxt;

  // digit scan
  logic [4:0]  int_top, frac_lo;
  logic        frac_any;

  function automatic logic [NDIG*4-1:0] add3(input logic [NDIG*4-1:0] b);
    logic [NDIG*4-1:0] r;
    begin
      r = b;
      for (int i = 0; i < NDIG; i++) begin
        if (b[i*4 +: 4] >= 4'd5) begin
          r[i*4 +: 4] = b[i*4 +: 4] + 4'd3;
        end
      end
      return r;
    end
  endfunction

  assign x_big    = (x_r[XW-1:53] != '0);
  assign emit_ok  = emit_valid && (!out_valid_r || out_pop);
  assign job_pop  = (state_r == ST_IDLE) && job_valid;
  assign ibcd_adj = add3(ibcd_r);
  assign fbcd_adj = add3(fbcd_r);

  always_comb begin
    rnd_m  = {1'b0, x_r[52:0]} + 54'(guard_r & (sticky_r | x_r[0]));
    sh     = {1'b0, s_r} - {5'b0, q_r};
    neg_sh = 12'd0 - sh;
    sum66  = {12'b0, rnd_m} + (66'd1 << (sh[5:0] - 6'd1));
    shr66  = sum66 >> sh[5:0];
    if (sh[11]) begin
      t_nxt = (neg_sh > 12'd63) ? 64'd0 : ({10'b0, rnd_m} << neg_sh[5:0]);
    end else if (sh == 12'd0) begin
      t_nxt = {10'b0, rnd_m};
    end else if (sh > 12'd63) begin
      t_nxt = 64'd0;
    end else begin
      t_nxt = shr66[63:0];
    end
  end

  always_comb begin
    int_top  = '0;
    frac_lo  = '0;
    frac_any = 1'b0;
    for (int i = 0; i < NDIG; i++) begin
      if (ibcd_r[i*4 +: 4] != 4'd0) begin
        int_top = 5'(i);
      end
    end
    for (int i = NDIG - 1; i >= 0; i--) begin
      if (fbcd_r[i*4 +: 4] != 4'd0) begin
        frac_lo  = 5'(i);
        frac_any = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (job_valid) state_nxt = job.err ? ST_ERR : ST_MUL;
      ST_MUL:   if (cnt_r == 6'd0) state_nxt = ST_NORM;
      ST_NORM:  if (!x_big) state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_CARRY;
      ST_CARRY: state_nxt = ST_CONV;
      ST_CONV:  if (cnt_r == 6'd63) state_nxt = ST_SCAN;
      ST_SCAN:  state_nxt = neg_r ? ST_SIGN : ST_INT;
      ST_SIGN:  if (emit_ok) state_nxt = ST_INT;
      ST_INT: begin
        if (emit_ok && ptr_r == 5'd0) state_nxt = (d_r != 5'd0) ? ST_DOT : ST_IDLE;
      end
      ST_DOT:   if (emit_ok) state_nxt = ST_FRAC;
      ST_FRAC:  if (emit_ok && ptr_r == fstop_r) state_nxt = ST_IDLE;
      ST_ERR:   if (emit_ok) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    emit_valid = 1'b0;
    emit_char  = CH_NUL;
    emit_last  = 1'b0;
    emit_oor   = 1'b0;
    unique case (state_r)
      ST_SIGN: begin
        emit_valid = 1'b1;
        emit_char  = CH_MINUS;
      end
      ST_INT: begin
        emit_valid = 1'b1;
        emit_char  = CH_ZERO | {3'b0, ibcd_r[ptr_r*4 +: 4]};
        emit_last  = (ptr_r == 5'd0) && (d_r == 5'd0);
      end
      ST_DOT: begin
        emit_valid = 1'b1;
        emit_char  = CH_DOT;
      end
      ST_FRAC: begin
        emit_valid = 1'b1;
        emit_char  = CH_ZERO | {3'b0, fbcd_r[ptr_r*4 +: 4]};
        emit_last  = (ptr_r == fstop_r);
      end
      ST_ERR: begin
        emit_valid = 1'b1;
        emit_last  = 1'b1;
        emit_oor   = 1'b1;
      end
      default: emit_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ok) begin
      out_char_r <= emit_char;
      out_last_r <= emit_last;
      out_oor_r  <= emit_oor;
    end
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          neg_r     <= job.neg;
          compact_r <= job.compact;
          whole_r   <= job.whole;
          s_r       <= job.shift;
          d_r       <= job.digits;
          x_r       <= XW'(job.frac);
          cnt_r     <= {1'b0, job.digits};
          q_r       <= '0;
          guard_r   <= 1'b0;
          sticky_r  <= 1'b0;
        end
      end
      ST_MUL: begin
        // times ten: x*8 + x*2
        if (cnt_r != 6'd0) begin
          x_r   <= (x_r << 3) + (x_r << 1);
          cnt_r <= cnt_r - 6'd1;
        end
      end
      ST_NORM: begin
        // drop one bit towards 53 significant bits
        if (x_big) begin
          sticky_r <= sticky_r | guard_r;
          guard_r  <= x_r[0];
          x_r      <= x_r >> 1;
          q_r      <= q_r + 7'd1;
        end
      end
      ST_ROUND: t_r <= t_nxt;
      ST_CARRY: begin
        if (t_r >= pow10(d_r)) begin
          ip_sh_r <= {10'b0, whole_r} + 64'd1;
          fp_sh_r <= '0;
        end else begin
          ip_sh_r <= {10'b0, whole_r};
          fp_sh_r <= t_r;
        end
        ibcd_r <= '0;
        fbcd_r <= '0;
        cnt_r  <= '0;
      end
      ST_CONV: begin
        ibcd_r  <= {ibcd_adj[NDIG*4-2:0], ip_sh_r[63]};
        fbcd_r  <= {fbcd_adj[NDIG*4-2:0], fp_sh_r[63]};
        ip_sh_r <= {ip_sh_r[62:0], 1'b0};
        fp_sh_r <= {fp_sh_r[62:0], 1'b0};
        cnt_r   <= cnt_r + 6'd1;
      end
      ST_SCAN: begin
        ptr_r <= int_top;
        if (!compact_r) begin
          fstop_r <= '0;
        end else begin
          fstop_r <= frac_any ? frac_lo : d_r - 5'd1;
        end
      end
      ST_INT:  if (emit_ok && ptr_r != 5'd0) ptr_r <= ptr_r - 5'd1;
      ST_DOT:  if (emit_ok) ptr_r <= d_r - 5'd1;
      ST_FRAC: if (emit_ok && ptr_r != fstop_r) ptr_r <= ptr_r - 5'd1;
      default: ;
    endcase
  end

  assign out_empty        = !out_valid_r;
  assign out_text_char    = out_char_r;
  assign out_last_char    = out_last_r;
  assign out_out_of_range = out_oor_r;

  a_oor_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_oor_r |-> out_last_r)
    else $error("error word without last flag");

  a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_NORM |-> q_r <= 7'd60)
    else $error("normalising shift ran past the product width");

  a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CONV && cnt_r == 6'd0 |-> fp_sh_r < pow10(d_r))
    else $error("rounded fraction not below 10^d after carry");

endmodule

// ===== rtl/core/double_to_fixed_decimal_text_top.sv =====
// Top level of the binary64 to fixed-point decimal text formatter.
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   --------------------------
//  input     in_value_bits                           in_push, in_full
//  result    out_text_char, out_last_char,           out_pop, out_empty
//            out_out_of_range
//  config    cfg_index, cfg_wdata                    cfg_we (no wait, no read)
//
// A word holds the back end for d times-ten steps (d is the clamped digit count,
// at most 18), q one-bit normalising shifts (at most 60), a shift-and-add-3 BCD
// conversion of both parts, the round, carry and scan hand-over states, and n
// characters at one a cycle while the output register is free (at most 36).
// An out-of-range word skips all of that and emits a single error word.
// Reset is synchronous, active low, and clears the queue and both registers.
// A full output register stalls only the back end; the two-entry front queue
// keeps taking words until it fills.
module double_to_fixed_decimal_text_top import dtfd_pkg::*; #(
  parameter int MAX_FRACTION_DIGITS = 18,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [63:0] in_value_bits,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [6:0]  out_text_char,
  output logic        out_last_char,
  output logic        out_out_of_range,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_wdata
);

  logic [4:0] fraction_digits_r;
  logic       compact_mode_r;

  job_t front_job, back_job;
  logic q_empty, q_pop;

  // configuration: unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fraction_digits_r <= '0;
      compact_mode_r    <= 1'b0;
    end else if (cfg_we && !cfg_index[1]) begin
      if (cfg_index[0] == REG_FRACTION_DIGITS) begin
        fraction_digits_r <= cfg_wdata;
      end else if (cfg_index[0] == REG_COMPACT_MODE) begin
        compact_mode_r <= cfg_wdata[0];
      end
    end
  end

  // classify and split the word as it arrives
  dtfd_front #(
    .MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)
  ) u_front (
    .value_bits      (in_value_bits),
    .fraction_digits (fraction_digits_r),
    .compact_mode    (compact_mode_r),
    .job             (front_job)
  );

  // hold decoded words until the back end is free
  dtfd_queue #(
    .WIDTH($bits(job_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_job),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (back_job),
    .empty (q_empty)
  );

  // scale, round, convert and emit the characters of each word
  dtfd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job              (back_job),
    .job_valid        (!q_empty),
    .job_pop          (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_text_char    (out_text_char),
    .out_last_char    (out_last_char),
    .out_out_of_range (out_out_of_range)
  );

endmodule

// ===== tb/double_to_fixed_decimal_text_top_tb.sv =====
// Testbench for the binary64 to fixed-point decimal text formatter.
`timescale 1ns / 1ps

module double_to_fixed_decimal_text_top_tb;
  import dtfd_pkg::*;

  // Cycles to let the back end settle before touching a register.
  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_LIMIT   = 20000;
  localparam int MAX_DIGITS    = 18;

  typedef enum logic [1:0] {K_VALUE, K_CONFIG, K_DRAIN} job_kind_t;

  typedef struct {
    job_kind_t   kind;
    logic [63:0] value;
    logic [1:0]  index;
    logic [4:0]  wdata;
  } stim_t;

  typedef struct {
    logic [6:0] ch;
    logic       last;
    logic       oor;
  } char_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [63:0] in_value_bits = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [6:0]  out_text_char;
  logic        out_last_char;
  logic        out_out_of_range;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [4:0]  cfg_wdata = '0;

  stim_t      pending_q[$];
  char_word_t text_q[$];
  int         mismatches = 0;
  int         idle_cycles = 0;
  int         cycle_no = 0;

  // shadow of the formatter's registers, updated as the driver writes them
  logic [4:0] sh_digits = '0;
  logic       sh_compact = 1'b0;

  double_to_fixed_decimal_text_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_value_bits(in_value_bits),
    .out_empty(out_empty), .out_pop(out_pop), .out_text_char(out_text_char),
    .out_last_char(out_last_char), .out_out_of_range(out_out_of_range),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Truncate a nonnegative real below 2^63 towards zero; the cast rounds.
  function automatic longint trunc_real(input real x);
    longint t;
    t = longint'(x);
    if (real'(t) > x) t = t - 1;
    return t;
  endfunction

  function automatic longint round_half_up(input real x);
    longint t;
    t = trunc_real(x);
    if (x - real'(t) >= 0.5) t = t + 1;
    return t;
  endfunction

  function automatic real ten_pow(input int d);
    real p;
    p = 1.0;
    for (int i = 0; i < d; i++) p = p * 10.0;
    return p;
  endfunction

  function automatic void push_char(input logic [6:0] c, input logic last);
    char_word_t w;
    w.ch = c;
    w.last = last;
    w.oor = 1'b0;
    text_q.push_back(w);
  endfunction

  // Work out the text of one accepted word under the current register values.
  function automatic void predict_text(input logic [63:0] bits);
    logic [62:0] mag;
    int          d;
    int          n;
    real         af;
    real         prod;
    real         fr;
    longint      whole;
    longint      int_val;
    longint      frac;
    logic [6:0]  line[$];
    logic [6:0]  idig[$];
    logic [6:0]  fdig[MAX_DIGITS];
    char_word_t  w;
    mag = bits[62:0];
    if (mag[62:52] == EXP_ALL || mag > MAG_TWO_53) begin
      w.ch = CH_NUL;
      w.last = 1'b1;
      w.oor = 1'b1;
      text_q.push_back(w);
      return;
    end
    d = (sh_digits > MAX_DIGITS) ? MAX_DIGITS : int'(sh_digits);
    af = $bitstoreal({1'b0, mag});
    frac = 0;
    if (d != 0) begin
      whole = trunc_real(af);
      prod = (af - real'(whole)) * ten_pow(d);
      fr = real'(round_half_up(prod));
      int_val = whole;
      if (fr >= ten_pow(d)) begin
        int_val = int_val + 1;
      end else begin
        frac = trunc_real(fr);
      end
    end else begin
      int_val = round_half_up(af);
    end
    if (bits[63] && mag != 0) line.push_back(CH_MINUS);
    do begin
      idig.push_front(CH_ZERO + 7'(int_val % 10));
      int_val = int_val / 10;
    end while (int_val != 0);
    foreach (idig[i]) line.push_back(idig[i]);
    if (d != 0) begin
      line.push_back(CH_DOT);
      for (int i = d - 1; i >= 0; i--) begin
        fdig[i] = CH_ZERO + 7'(frac % 10);
        frac = frac / 10;
      end
      n = d;
      if (sh_compact) begin
        while (n > 0 && fdig[n - 1] == CH_ZERO) n--;
        if (n == 0) n = 1;
      end
      for (int i = 0; i < n; i++) line.push_back(fdig[i]);
    end
    foreach (line[i]) push_char(line[i], i == line.size() - 1);
  endfunction

  function automatic void add_value(input logic [63:0] v);
    stim_t s;
    s.kind = K_VALUE;
    s.value = v;
    s.index = '0;
    s.wdata = '0;
    pending_q.push_back(s);
  endfunction

  function automatic void add_config(input logic [1:0] idx, input logic [4:0] data);
    stim_t s;
    s.kind = K_CONFIG;
    s.value = '0;
    s.index = idx;
    s.wdata = data;
    pending_q.push_back(s);
  endfunction

  function automatic void add_drain();
    stim_t s;
    s.kind = K_DRAIN;
    s.value = '0;
    s.index = '0;
    s.wdata = '0;
    pending_q.push_back(s);
  endfunction

  function automatic void add_setting(input logic [4:0] digits, input logic compact);
    add_config(2'(REG_FRACTION_DIGITS), digits);
    add_config(2'(REG_COMPACT_MODE), {4'd0, compact});
  endfunction

  // Pick a random word, weighted towards values that print and round.
  function automatic logic [63:0] random_value();
    logic        sgn;
    int unsigned n;
    int unsigned k;
    sgn = 1'($urandom);
    case ($urandom_range(0, 7))
      0: return {$urandom, $urandom};
      1: return {sgn, 11'($urandom_range(1000, 1076)), 52'({$urandom, $urandom})};
      2: begin
        n = $urandom_range(0, 99999);
        k = $urandom_range(0, 6);
        return {sgn, 63'($realtobits(real'(n) / ten_pow(k)))};
      end
      3: return {sgn, 63'($realtobits(real'($urandom_range(0, 1000)) + 0.5))};
      4: return {sgn, 11'($urandom_range(0, 1022)), 52'({$urandom, $urandom})};
      5: return {sgn, 11'($urandom_range(1070, 1077)), 52'({$urandom, $urandom})};
      6: return {sgn, 63'($realtobits(real'($urandom_range(0, 999)) + 0.005 *
                                      real'($urandom_range(0, 199))))};
      default: return {sgn, 11'h7FF, 52'($urandom_range(0, 3))};
    endcase
  endfunction

  // Fill the item queue: directed words first, then random phases.
  initial begin
    // reset setting: no fraction digits, plain rounding
    add_value(64'h0000000000000000);                   // zero
    add_value(64'h8000000000000000);                   // minus zero, no sign
    add_value($realtobits(1.5));
    add_value($realtobits(-2.5));
    add_value($realtobits(0.49999999999999994));
    add_value(64'h4340000000000000);                   // exactly 2^53
    add_value(64'hC340000000000001);                   // just above 2^53
    add_value(64'h7FF0000000000000);                   // infinity
    add_value(64'hFFF0000000000000);
    add_value(64'h7FF8000000000001);                   // NaN
    add_value(64'hFFFFFFFFFFFFFFFF);
    add_setting(5'd2, 1'b0);
    add_value($realtobits(-0.001));                    // sign kept on a zero text
    add_value($realtobits(0.995));
    add_value($realtobits(9.999));                     // fraction carries over
    add_value(64'h0000000000000001);                   // smallest subnormal
    add_value(64'h433FFFFFFFFFFFFF);
    add_setting(5'd31, 1'b1);                          // clamped to eighteen digits
    add_value($realtobits(0.1));
    add_value($realtobits(-4503599627370495.5));
    add_value(64'h4340000000000000);
    add_value($realtobits(2.0));                       // compact keeps one zero
    add_config(2'd2, 5'd7);                            // index without a register
    add_config(2'd3, 5'd31);
    add_value($realtobits(123.456));
    add_drain();

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: add_setting(5'd18, 1'b0);
        1: add_setting(5'd0, 1'b1);
        2: add_setting(5'd1, 1'b1);
        3: add_setting(5'd18, 1'b1);
        default: add_setting(5'($urandom_range(0, 31)), 1'($urandom));
      endcase
      for (int i = 0; i < 16; i++) begin
        add_value(random_value());
        if (p == 4 && i == 8) add_drain();
      end
    end
  end

  // Driver: words leave in bursts; register writes and drains wait for quiet.
  always @(posedge clk) begin
    static int burst_left = 0;
    static int gap_left = 0;
    static int settle = 0;
    logic       push_nx;
    logic       we_nx;
    logic       busy;
    stim_t      head;
    push_nx = in_push;
    we_nx = 1'b0;
    if (rst_n) begin
      if (in_push && !in_full) predict_text(in_value_bits);
      busy = in_push && in_full;
      if (!busy) begin
        push_nx = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() != 0) begin
          head = pending_q[0];
          if (head.kind != K_VALUE) begin
            // hold until every expected word is out and the back end is quiet
            if (text_q.size() == 0 && !(in_push && !in_full)) settle++;
            else settle = 0;
            if (settle >= SETTLE_CYCLES) begin
              settle = 0;
              void'(pending_q.pop_front());
              if (head.kind == K_CONFIG) begin
                we_nx = 1'b1;
                cfg_index <= head.index;
                cfg_wdata <= head.wdata;
                if (head.index == 2'(REG_FRACTION_DIGITS)) sh_digits = head.wdata;
                else if (head.index == 2'(REG_COMPACT_MODE)) sh_compact = head.wdata[0];
              end
            end
          end else begin
            push_nx = 1'b1;
            in_value_bits <= head.value;
            void'(pending_q.pop_front());
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(0, 12);
              gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
          end
        end
      end
    end
    in_push <= push_nx;
    cfg_we <= we_nx;
  end

  // Monitor: pop on a pattern that steps through four modes, then check.
  always @(posedge clk) begin
    char_word_t want;
    int         mode;
    cycle_no++;
    mode = (cycle_no / 300) % 4;
    case (mode)
      0: out_pop <= 1'b1;
      1: out_pop <= 1'($urandom);
      2: out_pop <= (cycle_no % 5) == 0;
      default: out_pop <= (cycle_no % 64) > 20;
    endcase
    if (rst_n && out_pop && !out_empty) begin
      if (text_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: char %h last %b oor %b", out_text_char,
                   out_last_char, out_out_of_range);
      end else begin
        want = text_q.pop_front();
        if (want.ch !== out_text_char || want.last !== out_last_char ||
            want.oor !== out_out_of_range) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected char %h last %b oor %b, got %h %b %b",
                     want.ch, want.last, want.oor, out_text_char, out_last_char,
                     out_out_of_range);
        end
      end
    end
  end

  // Watchdog: count cycles in which no word moves on either side and no register is written.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** double_to_fixed_decimal_text_top: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_q.size() != 0 || in_push || text_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && text_q.size() == 0) begin
      $display("** double_to_fixed_decimal_text_top: PASSED **");
    end else begin
      $display("** double_to_fixed_decimal_text_top: FAILED **");
    end
    $finish;
  end

endmodule
